### src/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
package bra_pkg;

    localparam int WORD_BITS          = 32;
    localparam int MAX_WORDS          = 32;
    localparam int DEFAULT_WORD_COUNT = 32;
    localparam int INDEX_W            = 10;
    localparam int LEN_W              = 11;
    localparam int CFG_W              = 6;
    localparam int FUNC_W             = 3;

    localparam logic [WORD_BITS-1:0] ALL_USED    = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0]     WORDS_RESET = 6'd32;

    localparam logic [FUNC_W-1:0] FUNC_SET       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCAN      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SCAN_MARK = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] bit_index;
        logic [LEN_W-1:0]   run_length;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] start_index;
        logic               bit_value;
        logic               error;
    } out_item_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_init;
        logic scan_step;
        logic bit_step;
        logic mark_init;
        logic mark_step;
        logic set_err;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_bit_op;
        logic is_scan;
        logic is_mark;
        logic in_range;
        logic scan_bad;
        logic scan_found;
        logic scan_last;
        logic mark_last;
    } status_t;

endpackage

### src/bra_datapath.sv
// Datapath of the bitmap run allocator: bitmap memory, scan logic and result register.
module bra_datapath #(
    parameter int WORD_COUNT = bra_pkg::DEFAULT_WORD_COUNT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bra_pkg::CFG_W-1:0]      cfg_wr_data,
    input  bra_pkg::in_item_t              s_data,
    input  bra_pkg::cmd_t                  cmd,
    output bra_pkg::status_t               status,
    output bra_pkg::out_item_t             m_data
);

    // Only words reachable by a 10-bit index are stored.
    localparam int DEPTH = (WORD_COUNT < bra_pkg::MAX_WORDS) ? WORD_COUNT : bra_pkg::MAX_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]             LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [bra_pkg::CFG_W-1:0] DEPTH_W   = bra_pkg::CFG_W'(DEPTH);

    logic [bra_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [bra_pkg::WORD_BITS-1:0] rdata_reg;

    logic [bra_pkg::CFG_W-1:0]   words_reg;
    logic [bra_pkg::FUNC_W-1:0]  func_reg;
    logic [bra_pkg::INDEX_W-1:0] idx_reg;
    logic [bra_pkg::LEN_W-1:0]   len_reg;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [4:0]                  cur_reg;
    logic [bra_pkg::LEN_W-1:0]   carry_reg;
    logic [bra_pkg::INDEX_W-1:0] run_start_reg;
    logic [bra_pkg::INDEX_W-1:0] start_reg;
    logic                        value_reg;
    logic                        err_reg;
    bra_pkg::out_item_t          m_data_reg;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [bra_pkg::WORD_BITS-1:0] wr_data;

    logic [bra_pkg::CFG_W-1:0]     eff_words;
    logic [bra_pkg::LEN_W-1:0]     limit;
    logic [AW-1:0]                 ptr_inc;
    logic [AW-1:0]                 load_ptr;
    logic [4:0]                    load_word;
    logic [bra_pkg::WORD_BITS-1:0] bit_mask;

    logic [5:0]                    tz, lz;
    logic [bra_pkg::LEN_W-1:0]     need;
    logic                          carry_hit;
    logic [bra_pkg::WORD_BITS-1:0] len_mask;
    logic                          fit_any;
    logic [4:0]                    fit_pos;
    logic [bra_pkg::INDEX_W-1:0]   base;
    logic [bra_pkg::INDEX_W-1:0]   found_start;
    logic                          scan_found;

    logic [bra_pkg::LEN_W-1:0]     end_idx, end_m1;
    logic [bra_pkg::LEN_W-1:0]     bit_pos;
    logic [bra_pkg::WORD_BITS-1:0] mark_mask;

    assign eff_words = (words_reg < DEPTH_W) ? words_reg : DEPTH_W;
    assign limit     = {eff_words[5:0], 5'b0};
    assign ptr_inc   = (ptr_reg == LAST_ADDR) ? ptr_reg : ptr_reg + 1'b1;
    assign bit_mask  = bra_pkg::WORD_BITS'(1) << idx_reg[4:0];
    assign base      = {cur_reg, 5'b0};

    assign load_word = s_data.bit_index[9:5];
    always_comb begin
        load_ptr = '0;
        if (s_data.func != bra_pkg::FUNC_SCAN && s_data.func != bra_pkg::FUNC_SCAN_MARK &&
            bra_pkg::CFG_W'(load_word) < DEPTH_W) begin
            load_ptr = AW'(load_word);
        end
    end

    // Free-bit counts at either end of the word under scan.
    always_comb begin
        tz = 6'd32;
        lz = 6'd32;
        for (int p = bra_pkg::WORD_BITS - 1; p >= 0; p--) begin
            if (rdata_reg[p]) begin
                tz = 6'(p);
            end
        end
        for (int p = 0; p < bra_pkg::WORD_BITS; p++) begin
            if (rdata_reg[p]) begin
                lz = 6'(bra_pkg::WORD_BITS - 1 - p);
            end
        end
    end

    // A run either completes the one carried in from lower words, or lies inside this word.
    always_comb begin
        need      = len_reg - carry_reg;
        carry_hit = {5'b0, tz} >= need;
        len_mask  = (len_reg[10:5] != 6'd0) ? bra_pkg::ALL_USED
                                            : ~(bra_pkg::ALL_USED << len_reg[4:0]);
        fit_any   = 1'b0;
        fit_pos   = '0;
        for (int s = bra_pkg::WORD_BITS - 1; s >= 0; s--) begin
            if (len_reg <= 11'(bra_pkg::WORD_BITS - s) &&
                ((rdata_reg >> s) & len_mask) == '0) begin
                fit_any = 1'b1;
                fit_pos = 5'(s);
            end
        end
        scan_found = carry_hit || fit_any;
        if (carry_hit) begin
            found_start = (carry_reg == '0) ? base : run_start_reg;
        end else begin
            found_start = {cur_reg, fit_pos};
        end
    end

    always_comb begin
        end_idx = {1'b0, start_reg} + len_reg;
        end_m1  = end_idx - 1'b1;
        for (int p = 0; p < bra_pkg::WORD_BITS; p++) begin
            bit_pos      = {1'b0, cur_reg, 5'(p)};
            mark_mask[p] = (bit_pos >= {1'b0, start_reg}) && (bit_pos < end_idx);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = '0;
        if (cmd.clear_step) begin
            wr_en = 1'b1;
        end else if (cmd.bit_step) begin
            if (func_reg == bra_pkg::FUNC_SET) begin
                wr_en   = 1'b1;
                wr_data = rdata_reg | bit_mask;
            end else if (func_reg == bra_pkg::FUNC_CLEAR) begin
                wr_en   = 1'b1;
                wr_data = rdata_reg & ~bit_mask;
            end
        end else if (cmd.mark_step) begin
            wr_en   = 1'b1;
            wr_addr = AW'(cur_reg);
            wr_data = rdata_reg | mark_mask;
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.load) begin
            ptr_next = load_ptr;
        end else if (cmd.scan_step && scan_found) begin
            ptr_next = AW'(found_start[9:5]);
        end else if (cmd.clear_step || cmd.scan_init || cmd.scan_step ||
                     cmd.mark_init || cmd.mark_step) begin
            ptr_next = ptr_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= bra_pkg::WORDS_RESET;
            ptr_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                words_reg <= cfg_wr_data;
            end
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_data.func;
            idx_reg   <= s_data.bit_index;
            len_reg   <= s_data.run_length;
            start_reg <= '0;
            value_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        if (cmd.set_err) begin
            err_reg <= 1'b1;
        end
        if (cmd.bit_step && func_reg == bra_pkg::FUNC_TEST) begin
            value_reg <= rdata_reg[idx_reg[4:0]];
        end
        if (cmd.scan_init) begin
            cur_reg       <= '0;
            carry_reg     <= '0;
            run_start_reg <= '0;
        end
        if (cmd.scan_step) begin
            cur_reg <= cur_reg + 1'b1;
            if (scan_found) begin
                start_reg <= found_start;
            end else begin
                if (status.scan_last) begin
                    err_reg <= 1'b1;
                end
                if (rdata_reg == '0) begin
                    carry_reg <= carry_reg + 11'(bra_pkg::WORD_BITS);
                    if (carry_reg == '0) begin
                        run_start_reg <= base;
                    end
                end else begin
                    carry_reg     <= {5'b0, lz};
                    run_start_reg <= base + 10'(bra_pkg::WORD_BITS) - {4'b0, lz};
                end
            end
        end
        if (cmd.mark_init) begin
            cur_reg <= 5'(ptr_reg);
        end
        if (cmd.mark_step) begin
            cur_reg <= cur_reg + 1'b1;
        end
        if (cmd.result_load) begin
            m_data_reg.start_index <= start_reg;
            m_data_reg.bit_value   <= value_reg;
            m_data_reg.error       <= err_reg;
        end
    end

    assign status.clear_last = (ptr_reg == LAST_ADDR);
    assign status.is_bit_op  = (func_reg == bra_pkg::FUNC_SET) ||
                               (func_reg == bra_pkg::FUNC_CLEAR) ||
                               (func_reg == bra_pkg::FUNC_TEST);
    assign status.is_scan    = (func_reg == bra_pkg::FUNC_SCAN) ||
                               (func_reg == bra_pkg::FUNC_SCAN_MARK);
    assign status.is_mark    = (func_reg == bra_pkg::FUNC_SCAN_MARK);
    assign status.in_range   = {1'b0, idx_reg[9:5]} < eff_words;
    assign status.scan_bad   = (len_reg == '0) || (len_reg > limit);
    assign status.scan_found = scan_found;
    assign status.scan_last  = ({1'b0, cur_reg} == eff_words - 6'd1);
    assign status.mark_last  = (cur_reg == end_m1[9:5]);

    assign m_data = m_data_reg;

endmodule

### src/bra_ctrl.sv
// Control state machine of the bitmap run allocator.
module bra_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  bra_pkg::status_t status,
    output bra_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_DISPATCH  = 8'b0000_0100,
        S_BIT       = 8'b0000_1000,
        S_SCAN      = 8'b0001_0000,
        S_MARK_INIT = 8'b0010_0000,
        S_MARK      = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (status.is_bit_op) begin
                    state_next = status.in_range ? S_BIT : S_FINISH;
                end else if (status.is_scan) begin
                    if (status.scan_bad) begin
                        cmd.set_err = 1'b1;
                        state_next  = S_FINISH;
                    end else begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_BIT: begin
                cmd.bit_step = 1'b1;
                state_next   = S_FINISH;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_found) begin
                    state_next = status.is_mark ? S_MARK_INIT : S_FINISH;
                end else if (status.scan_last) begin
                    state_next = S_FINISH;
                end
            end
            S_MARK_INIT: begin
                cmd.mark_init = 1'b1;
                state_next    = S_MARK;
            end
            S_MARK: begin
                cmd.mark_step = 1'b1;
                if (status.mark_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // The result register frees up in the same cycle its item is taken.
                if (!m_valid_reg || m_ready) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### src/bitmap_run_allocator.sv
// Top level of the first-fit bitmap run allocator.
// After reset the block sweeps the bitmap memory to zero, one word a cycle, and takes no
// item until the sweep is done; configuration writes are taken throughout.
// Items are handled one at a time, and the next item can be accepted in the cycle after
// the previous result is loaded. Set, clear and test pass through a dispatch state and
// a bit step, spent on the memory's registered read and, for set and clear, the write
// back. An index out of range, an unknown function or a scan with a bad length gives
// its result straight from the dispatch state. A scan passes through the dispatch
// state and then one scan step per word examined, as the scan unit looks at one 32-bit
// word per cycle; scan-and-mark adds a mark set-up state and then one mark step for
// each word the run touches, as each is read, merged and written back. A finished
// result waits in an output register while the next item is accepted; an item whose
// result is ready stalls while that register still holds a result that has not been
// taken.
module bitmap_run_allocator #(
    parameter int WORD_COUNT = bra_pkg::DEFAULT_WORD_COUNT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bra_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bra_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bra_pkg::out_item_t        m_data
);

    bra_pkg::cmd_t    cmd;
    bra_pkg::status_t status;

    bra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bra_datapath #(
        .WORD_COUNT (WORD_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_data      (m_data)
    );

endmodule
